// ===== hdl/dptt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptt_pkg
// Shared types and constants of the delayed periodic timer table.
// ----------------------------------------------------------------------------
package dptt_pkg;

  localparam int TIMER_SLOTS_DEF = 32;
  localparam int ID_BASE_DEF     = 100;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;

  localparam logic [1:0] KIND_ADD_DONE  = 2'd0;
  localparam logic [1:0] KIND_FIRED     = 2'd1;
  localparam logic [1:0] KIND_STOP_DONE = 2'd2;
  localparam logic [1:0] KIND_TICK_DONE = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [30:0]        first_delay;
    logic [30:0]        period;
    logic signed [31:0] user_word_a;
    logic signed [31:0] user_word_b;
    logic [7:0]         target_id;
    logic [15:0]        elapsed;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         timer_ident;
    logic signed [31:0] out_word_a;
    logic signed [31:0] out_word_b;
    logic               ok;
    logic               last;
  } out_t;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_STOP,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        period_zero;
    logic        delay_zero;
    logic [7:0]  stop_slot;
    logic        stop_in_range;
    logic [30:0] first_delay;
    logic [30:0] period;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [7:0]  target_id;
    logic [15:0] elapsed;
  } cmd_t;

  typedef struct packed {
    logic [30:0] delay_left;
    logic [30:0] repeat_period;
    logic [30:0] accumulated;
    logic [31:0] word_a;
    logic [31:0] word_b;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/delayed_periodic_timer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_periodic_timer_table
// Table of delayed periodic timers with add, stop and tick transactions.
// ----------------------------------------------------------------------------
// Transactions are queued two deep and executed one at a time. An add with
// zero delay gives a fired result and then its done result. A tick walks the
// timer table one slot per cycle through the table RAM, except where a fired
// result waits on a stalled result side. Timer identifiers are ID_BASE + slot,
// low 8 bits.
module delayed_periodic_timer_table
  import dptt_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int ID_BASE     = ID_BASE_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic head_valid;
  cmd_t head;
  logic pop;

  dptt_front #(.TIMER_SLOTS(TIMER_SLOTS), .ID_BASE(ID_BASE)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_i         (in_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  dptt_back #(.TIMER_SLOTS(TIMER_SLOTS), .ID_BASE(ID_BASE)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_o)
  );

endmodule

// ===== hdl/dptt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptt_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module dptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dptt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptt_front
// Accepts input transactions, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module dptt_front
  import dptt_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int ID_BASE     = ID_BASE_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic head_valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd;
  logic [7:0] diff;
  logic       push;

  always_comb begin
    diff = in_i.target_id - 8'(ID_BASE);
    unique case (in_i.operation)
      OP_ADD:  cmd.kind = CMD_ADD;
      OP_STOP: cmd.kind = CMD_STOP;
      default: cmd.kind = CMD_TICK;
    endcase
    cmd.period_zero   = (in_i.period == '0);
    cmd.delay_zero    = (in_i.first_delay == '0);
    cmd.stop_slot     = diff;
    cmd.stop_in_range = ({1'b0, diff} < 9'(TIMER_SLOTS));
    cmd.first_delay   = in_i.first_delay;
    cmd.period        = in_i.period;
    cmd.word_a        = in_i.user_word_a;
    cmd.word_b        = in_i.user_word_b;
    cmd.target_id     = in_i.target_id;
    cmd.elapsed       = in_i.elapsed;
  end

  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

// ===== hdl/dptt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptt_back
// Executes queued commands against the timer table and drives results.
// ----------------------------------------------------------------------------
module dptt_back
  import dptt_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int ID_BASE     = ID_BASE_DEF,
  localparam int SW         = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic head_valid_i,
  input  cmd_t head_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD_DONE,
    ST_TICK_EX,
    ST_TICK_DONE
  } state_e;

  state_e                 state_q;
  logic [TIMER_SLOTS-1:0] used_q;
  logic [SW-1:0]          cnt_q;
  logic [SW-1:0]          add_slot_q;
  logic                   any_q;
  logic                   out_valid_q;
  out_t                   out_q;

  logic          out_free;
  logic [SW-1:0] free_slot;
  logic          free_found;
  logic [SW-1:0] stop_idx;
  logic          stop_found;
  logic          we, re;
  logic [SW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [31:0]   sum;
  logic [30:0]   acc_sat;
  logic          take_delay, take_period, fire;
  entry_t        upd;
  logic          cur_used, last_slot;
  logic          tick_step;

  dptt_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMER_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int s = TIMER_SLOTS - 1; s >= 0; s--) begin
      if (!used_q[s]) begin
        free_slot  = SW'(s);
        free_found = 1'b1;
      end
    end
  end

  assign stop_idx   = head_i.stop_slot[SW-1:0];
  assign stop_found = head_i.stop_in_range && used_q[stop_idx];

  always_comb begin
    sum         = {1'b0, rdata.accumulated} + {16'd0, head_i.elapsed};
    acc_sat     = sum[31] ? 31'h7fff_ffff : sum[30:0];
    take_delay  = (rdata.delay_left != '0) && (rdata.delay_left <= acc_sat);
    take_period = !take_delay && (rdata.repeat_period <= acc_sat);
    upd         = rdata;
    if (take_delay) begin
      upd.accumulated = acc_sat - rdata.delay_left;
      upd.delay_left  = '0;
    end else if (take_period) begin
      upd.accumulated = acc_sat - rdata.repeat_period;
    end else begin
      upd.accumulated = acc_sat;
    end
    cur_used  = used_q[cnt_q];
    fire      = cur_used && (take_delay || take_period);
    last_slot = (cnt_q == SW'(TIMER_SLOTS - 1));
    tick_step = (state_q == ST_TICK_EX) && (!fire || out_free);
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = upd;
    re    = 1'b0;
    raddr = cnt_q + SW'(1);
    if (state_q == ST_IDLE && head_valid_i) begin
      if (head_i.kind == CMD_ADD) begin
        we    = out_free && !head_i.period_zero && free_found;
        waddr = free_slot;
        wdata = '{delay_left: head_i.first_delay, repeat_period: head_i.period,
                  accumulated: '0, word_a: head_i.word_a, word_b: head_i.word_b};
      end else if (head_i.kind == CMD_TICK) begin
        re    = 1'b1;
        raddr = '0;
      end
    end else if (tick_step) begin
      we = cur_used;
      re = !last_slot;
    end
  end

  always_comb begin
    pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE:      pop_o = head_valid_i && out_free && head_i.kind != CMD_TICK &&
                            !(head_i.kind == CMD_ADD && !head_i.period_zero &&
                              free_found && head_i.delay_zero);
      ST_ADD_DONE:  pop_o = out_free;
      ST_TICK_DONE: pop_o = out_free;
      default:      pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      cnt_q       <= '0;
      add_slot_q  <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            if (head_i.kind == CMD_TICK) begin
              cnt_q   <= '0;
              any_q   <= 1'b0;
              state_q <= ST_TICK_EX;
            end else if (out_free) begin
              out_valid_q       <= 1'b1;
              out_q.out_word_a  <= '0;
              out_q.out_word_b  <= '0;
              out_q.last        <= 1'b1;
              if (head_i.kind == CMD_STOP) begin
                out_q.kind        <= KIND_STOP_DONE;
                out_q.timer_ident <= head_i.target_id;
                out_q.ok          <= stop_found;
                if (stop_found) begin
                  used_q[stop_idx] <= 1'b0;
                end
              end else if (head_i.period_zero || !free_found) begin
                out_q.kind        <= KIND_ADD_DONE;
                out_q.timer_ident <= '0;
                out_q.ok          <= 1'b0;
              end else begin
                used_q[free_slot] <= 1'b1;
                out_q.timer_ident <= 8'(ID_BASE) + 8'(free_slot);
                out_q.ok          <= 1'b1;
                if (head_i.delay_zero) begin
                  out_q.kind       <= KIND_FIRED;
                  out_q.out_word_a <= head_i.word_a;
                  out_q.out_word_b <= head_i.word_b;
                  out_q.last       <= 1'b0;
                  add_slot_q       <= free_slot;
                  state_q          <= ST_ADD_DONE;
                end else begin
                  out_q.kind <= KIND_ADD_DONE;
                end
              end
            end
          end
        end
        ST_ADD_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= '{kind: KIND_ADD_DONE,
                             timer_ident: 8'(ID_BASE) + 8'(add_slot_q),
                             out_word_a: '0, out_word_b: '0, ok: 1'b1, last: 1'b1};
            state_q     <= ST_IDLE;
          end
        end
        ST_TICK_EX: begin
          if (tick_step) begin
            any_q <= any_q | cur_used;
            if (fire) begin
              out_valid_q <= 1'b1;
              out_q       <= '{kind: KIND_FIRED,
                               timer_ident: 8'(ID_BASE) + 8'(cnt_q),
                               out_word_a: rdata.word_a, out_word_b: rdata.word_b,
                               ok: 1'b1, last: 1'b0};
            end
            if (last_slot) begin
              state_q <= ST_TICK_DONE;
            end else begin
              cnt_q <= cnt_q + SW'(1);
            end
          end
        end
        ST_TICK_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= '{kind: KIND_TICK_DONE, timer_ident: '0,
                             out_word_a: '0, out_word_b: '0, ok: any_q, last: 1'b1};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the delayed periodic timer table: directed and
// random add, stop and tick transactions, predicted and compared per result.
// ----------------------------------------------------------------------------
module testbench
  import dptt_pkg::*;
;

  localparam int SLOTS = TIMER_SLOTS_DEF;
  localparam int BASE = ID_BASE_DEF;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_ALT_TICK = 2'd3;
  localparam int LIMIT = 400000;

  class timer_scoreboard;
    bit          used[SLOTS];
    logic [30:0] delay_left[SLOTS];
    logic [30:0] period[SLOTS];
    logic [30:0] accum[SLOTS];
    logic [31:0] word_a[SLOTS];
    logic [31:0] word_b[SLOTS];
    out_t        pending[$];
    int          errors;

    function void push(logic [1:0] k, logic [7:0] id, logic [31:0] a, logic [31:0] b,
                       logic ok, logic last);
      out_t r;
      r.kind = k;
      r.timer_ident = id;
      r.out_word_a = a;
      r.out_word_b = b;
      r.ok = ok;
      r.last = last;
      pending.insert(pending.size(), r);
    endfunction

    function void note_input(in_t t);
      int slot;
      logic any;
      logic [31:0] sum;
      logic fire;
      slot = -1;
      any = 0;
      if (t.operation == OP_ADD) begin
        if (t.period != 0) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!used[s] && slot < 0) slot = s;
          end
        end
        if (slot < 0) begin
          push(KIND_ADD_DONE, 8'd0, 0, 0, 1'b0, 1'b1);
        end else begin
          used[slot] = 1;
          delay_left[slot] = t.first_delay;
          period[slot] = t.period;
          accum[slot] = 0;
          word_a[slot] = t.user_word_a;
          word_b[slot] = t.user_word_b;
          if (t.first_delay == 0) begin
            push(KIND_FIRED, 8'(BASE + slot), t.user_word_a, t.user_word_b, 1'b1, 1'b0);
          end
          push(KIND_ADD_DONE, 8'(BASE + slot), 0, 0, 1'b1, 1'b1);
        end
      end else if (t.operation == OP_STOP) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (used[s] && 8'(BASE + s) == t.target_id && !any && BASE + s < 256) begin
            used[s] = 0;
            any = 1;
          end
        end
        push(KIND_STOP_DONE, t.target_id, 0, 0, any, 1'b1);
      end else begin
        for (int s = 0; s < SLOTS; s++) begin
          if (used[s]) begin
            any = 1;
            fire = 0;
            sum = {1'b0, accum[s]} + t.elapsed;
            if (sum > 32'h7fff_ffff) sum = 32'h7fff_ffff;
            if (delay_left[s] != 0 && delay_left[s] <= sum) begin
              sum -= delay_left[s];
              delay_left[s] = 0;
              fire = 1;
            end else if (period[s] <= sum) begin
              sum -= period[s];
              fire = 1;
            end
            accum[s] = sum[30:0];
            if (fire) push(KIND_FIRED, 8'(BASE + s), word_a[s], word_b[s], 1'b1, 1'b0);
          end
        end
        push(KIND_TICK_DONE, 8'd0, 0, 0, any, 1'b1);
      end
    endfunction

    function void check_result(out_t r);
      out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, r);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.kind !== e.kind || r.timer_ident !== e.timer_ident ||
          r.out_word_a !== e.out_word_a || r.out_word_b !== e.out_word_b ||
          r.ok !== e.ok || r.last !== e.last) begin
        $display("%0t: mismatch expected %h actual %h", $time, e, r);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid = 0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;
  int   cycles = 0;
  int   idle_pct = 31;
  bit   hold_off = 0;
  timer_scoreboard sb = new();

  always #1 clk_i = ~clk_i;

  delayed_periodic_timer_table i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      out_stall <= hold_off || ($urandom_range(99) < idle_pct);
    end
  end

  task automatic send(in_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk_i);
    end
    in_valid <= 1;
    in_data <= t;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_input(t);
  endtask

  function automatic in_t rand_item(logic [1:0] op);
    in_t t;
    t.operation = op;
    t.first_delay = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(300));
    t.period = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(200));
    t.user_word_a = $urandom;
    t.user_word_b = $urandom;
    t.target_id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(BASE + $urandom_range(33));
    t.elapsed = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(150));
    return t;
  endfunction

  function automatic in_t mk(logic [1:0] op, logic [30:0] d, logic [30:0] p,
                             logic [7:0] id, logic [15:0] el);
    in_t t;
    t = rand_item(op);
    t.first_delay = d;
    t.period = p;
    t.target_id = id;
    t.elapsed = el;
    return t;
  endfunction

  initial begin
    in_t t;
    int r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send(mk(OP_TICK, 0, 0, 0, 16'hffff));
    send(mk(OP_ADD, 5, 0, 0, 0));
    send(mk(OP_ADD, 0, 10, 0, 0));
    send(mk(OP_ADD, 31'h7fff_ffff, 31'h7fff_ffff, 0, 0));
    send(mk(OP_ADD, 20, 3, 0, 0));
    t = mk(OP_ADD, 1, 1, 0, 0);
    t.user_word_a = 32'h8000_0000;
    t.user_word_b = 32'hffff_ffff;
    send(t);
    send(mk(OP_TICK, 0, 0, 0, 0));
    send(mk(OP_TICK, 0, 0, 0, 25));
    send(mk(OP_ALT_TICK, 0, 0, 0, 16'hffff));
    send(mk(OP_STOP, 0, 0, 8'd101, 0));
    send(mk(OP_STOP, 0, 0, 8'd101, 0));
    send(mk(OP_STOP, 0, 0, 8'd255, 0));
    send(mk(OP_STOP, 0, 0, 8'd0, 0));
    for (int i = 0; i < 35; i++) send(mk(OP_ADD, 31'($urandom_range(9)), 31'h7fff_ffff, 0, 0));
    for (int i = 0; i < 10; i++) send(mk(OP_TICK, 0, 0, 0, 16'hffff));
    for (int s = 0; s < SLOTS; s++) send(mk(OP_STOP, 0, 0, 8'(BASE + s), 0));
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) send(rand_item(OP_ADD));
    join
    for (int i = 0; i < 100; i++) begin
      if (i == 30) idle_pct = 0;
      if (i == 70) idle_pct = 31;
      r = $urandom_range(99);
      if (r < 40) send(rand_item(OP_ADD));
      else if (r < 65) send(rand_item(OP_STOP));
      else send(rand_item(r < 95 ? OP_TICK : OP_ALT_TICK));
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/dptt_pkg.sv
hdl/dptt_ram.sv
hdl/dptt_front.sv
hdl/dptt_back.sv
hdl/delayed_periodic_timer_table.sv
dv/testbench.sv
